@@ src/rbc_pkg.sv @@
// rbc_pkg: types, constants and constant tables for the RDS block check/correct.
// Used by rbc_if.sv, rbc_syndrome.sv, rbc_trap.sv and rds_block_check_correct.sv.
`default_nettype none

package rbc_pkg;

  localparam int CwW         = 26;
  localparam int SynW        = 10;
  localparam int DataW       = 16;
  localparam int IdxW        = 2;
  localparam int BlenW       = 3;
  localparam int MaxBurstLen = 5;
  localparam int TrapSteps   = 27 - MaxBurstLen;
  localparam int VerBBit     = 11;

  localparam logic [SynW:0]   GenPoly  = 11'h5B9;
  localparam logic [SynW-1:0] OffsetA  = 10'h0FC;
  localparam logic [SynW-1:0] OffsetB  = 10'h198;
  localparam logic [SynW-1:0] OffsetC  = 10'h168;
  localparam logic [SynW-1:0] OffsetD  = 10'h1B4;
  localparam logic [SynW-1:0] OffsetCp = 10'h350;

  typedef enum logic [IdxW-1:0] {
    BlkA = 2'd0,
    BlkB = 2'd1,
    BlkC = 2'd2,
    BlkD = 2'd3
  } blk_pos_e;

  typedef enum logic [1:0] {
    StClean         = 2'd0,
    StCorrected     = 2'd1,
    StUncorrectable = 2'd2,
    StIdMismatch    = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CfgPiPrimary   = 1'b0,
    CfgPiSecondary = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [DataW-1:0] data_word;
    status_e          status;
    logic [BlenW-1:0] burst_length;
  } rbc_res_t;

  // column i: x^i mod g
  typedef logic [CwW-1:0][SynW-1:0] syn_tab_t;
  // [step][bit]: syndrome unit vector after that many trap shifts
  typedef logic [TrapSteps-1:0][SynW-1:0][SynW-1:0] trap_tab_t;

  function automatic syn_tab_t build_syn_tab();
    syn_tab_t        t;
    logic [SynW:0]   v;
    v = (SynW+1)'(1);
    for (int i = 0; i < CwW; i++) begin
      t[i] = v[SynW-1:0];
      v = {v[SynW-1:0], 1'b0};
      if (v[SynW]) v = v ^ GenPoly;
    end
    return t;
  endfunction

  function automatic trap_tab_t build_trap_tab();
    trap_tab_t     t;
    logic [SynW:0] s;
    for (int j = 0; j < SynW; j++) begin
      s = (SynW+1)'(1) << j;
      for (int i = 0; i < TrapSteps; i++) begin
        t[i][j] = s[SynW-1:0];
        if (s[0]) s = s ^ GenPoly;
        s = s >> 1;
      end
    end
    return t;
  endfunction

  localparam syn_tab_t  SynTab  = build_syn_tab();
  localparam trap_tab_t TrapTab = build_trap_tab();

  // lowest to highest set bit, inclusive; zero for an empty pattern
  function automatic logic [BlenW-1:0] span_of(input logic [MaxBurstLen-1:0] v);
    int   lo;
    int   hi;
    logic seen;
    lo   = 0;
    hi   = 0;
    seen = 1'b0;
    for (int k = 0; k < MaxBurstLen; k++) begin
      if (v[k]) begin
        hi = k;
        if (!seen) lo = k;
        seen = 1'b1;
      end
    end
    return seen ? BlenW'(hi - lo + 1) : '0;
  endfunction

endpackage

`default_nettype wire

@@ src/rbc_if.sv @@
// rbc_if: valid/ready channel interfaces for blocks in and results out.
// Depends on rbc_pkg for field widths.
`default_nettype none

interface rbc_blk_if;
  logic                       valid;
  logic                       ready;
  logic [rbc_pkg::CwW-1:0]    received_bits;
  logic [rbc_pkg::IdxW-1:0]   block_index;

  modport source (output valid, output received_bits, output block_index, input ready);
  modport sink   (input valid, input received_bits, input block_index, output ready);
endinterface

interface rbc_res_if;
  logic                       valid;
  logic                       ready;
  logic [rbc_pkg::DataW-1:0]  data_word;
  logic [1:0]                 status;
  logic [rbc_pkg::BlenW-1:0]  burst_length;

  modport source (output valid, output data_word, output status, output burst_length,
                  input ready);
  modport sink   (input valid, input data_word, input status, input burst_length,
                  output ready);
endinterface

`default_nettype wire

@@ src/rbc_syndrome.sv @@
// rbc_syndrome: 10-bit syndrome of a 26-bit block with the position offset removed.
// Depends on rbc_pkg (syndrome columns, offset words).
`default_nettype none

module rbc_syndrome (
  input  wire logic [rbc_pkg::CwW-1:0]  received_bits_i,
  input  wire logic [rbc_pkg::IdxW-1:0] block_index_i,
  input  wire logic                     ver_b_i,
  output logic      [rbc_pkg::SynW-1:0] syn_o
);

  logic [rbc_pkg::SynW-1:0] raw_syn;
  logic [rbc_pkg::SynW-1:0] offset;

  // division is linear: XOR of x^i mod g over the set bits
  always_comb begin
    raw_syn = '0;
    for (int i = 0; i < rbc_pkg::CwW; i++) begin
      if (received_bits_i[i]) raw_syn = raw_syn ^ rbc_pkg::SynTab[i];
    end
  end

  always_comb begin
    case (block_index_i)
      rbc_pkg::BlkA: offset = rbc_pkg::OffsetA;
      rbc_pkg::BlkB: offset = rbc_pkg::OffsetB;
      rbc_pkg::BlkC: offset = ver_b_i ? rbc_pkg::OffsetCp : rbc_pkg::OffsetC;
      rbc_pkg::BlkD: offset = rbc_pkg::OffsetD;
      default:       offset = rbc_pkg::OffsetA;
    endcase
  end

  assign syn_o = raw_syn ^ offset;

endmodule

`default_nettype wire

@@ src/rbc_trap.sv @@
// rbc_trap: error trapping over all shift counts in parallel, burst correction,
// status and identity check. Depends on rbc_pkg (trap table, status codes).
`default_nettype none

module rbc_trap (
  input  wire logic [rbc_pkg::SynW-1:0]  syn_i,
  input  wire logic [rbc_pkg::DataW-1:0] raw_data_i,
  input  wire logic [rbc_pkg::IdxW-1:0]  block_index_i,
  input  wire logic [rbc_pkg::DataW-1:0] pi_primary_i,
  input  wire logic [rbc_pkg::DataW-1:0] pi_secondary_i,
  output rbc_pkg::rbc_res_t              res_o
);

  logic [rbc_pkg::TrapSteps-1:0][rbc_pkg::SynW-1:0]  step_syn;
  logic [rbc_pkg::TrapSteps-1:0]                     hit;
  logic [rbc_pkg::TrapSteps-1:0][rbc_pkg::DataW-1:0] corr;
  logic                                              found;
  logic [rbc_pkg::MaxBurstLen-1:0]                   pat_sel;
  logic [rbc_pkg::DataW-1:0]                         corr_sel;
  logic [rbc_pkg::DataW-1:0]                         fixed;
  logic [rbc_pkg::BlenW-1:0]                         blen;

  // syndrome after i divide-by-x shifts, each a fixed linear map of syn_i
  always_comb begin
    for (int i = 0; i < rbc_pkg::TrapSteps; i++) begin
      logic [rbc_pkg::CwW-1:0] placed;
      step_syn[i] = '0;
      for (int j = 0; j < rbc_pkg::SynW; j++) begin
        if (syn_i[j]) step_syn[i] = step_syn[i] ^ rbc_pkg::TrapTab[i][j];
      end
      hit[i]  = (step_syn[i][rbc_pkg::SynW-1:rbc_pkg::MaxBurstLen] == '0);
      placed  = rbc_pkg::CwW'(step_syn[i]) << i;
      corr[i] = placed[rbc_pkg::CwW-1:rbc_pkg::SynW];
    end
  end

  // first trapping shift wins
  always_comb begin
    found    = 1'b0;
    pat_sel  = '0;
    corr_sel = '0;
    for (int i = 0; i < rbc_pkg::TrapSteps; i++) begin
      if (hit[i] && !found) begin
        found    = 1'b1;
        pat_sel  = step_syn[i][rbc_pkg::MaxBurstLen-1:0];
        corr_sel = corr[i];
      end
    end
  end

  assign fixed = raw_data_i ^ corr_sel;
  assign blen  = rbc_pkg::span_of(pat_sel);

  always_comb begin
    if (!found) begin
      res_o.data_word    = raw_data_i;
      res_o.status       = rbc_pkg::StUncorrectable;
      res_o.burst_length = '0;
    end else begin
      res_o.data_word    = fixed;
      res_o.burst_length = blen;
      res_o.status       = (blen != '0) ? rbc_pkg::StCorrected : rbc_pkg::StClean;
      // once a primary PI code is set, a repaired A block must carry a known PI code
      if (block_index_i == rbc_pkg::BlkA && pi_primary_i != '0 && blen != '0 &&
          fixed != pi_primary_i && fixed != pi_secondary_i) begin
        res_o.status = rbc_pkg::StIdMismatch;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/rds_block_check_correct.sv @@
// rds_block_check_correct: top level; input register, syndrome and trapping logic,
// result register, PI registers and version-B flag. Depends on rbc_pkg, rbc_if,
// rbc_syndrome and rbc_trap.
//
//   channel  dir  handshake      beat contents
//   blk_i    in   valid/ready    received_bits[25:0], block_index[1:0]
//   res_o    out  valid/ready    data_word[15:0], status[1:0], burst_length[2:0]
//   cfg      in   cfg_we_i       cfg_idx_i (0 pi_primary, 1 pi_secondary), cfg_wdata_i
//
// One beat per cycle sustained while res_o is ready; an accepted beat passes the input
// register and then the result register before it is offered on res_o.
// The syndrome, all trap shifts and the correction sit between the input and
// result registers. The version-B flag is taken from a B block as it leaves the
// input register, so the next block sees it. A stalled res_o holds its beat and
// the input register fills behind it; blk_i.ready drops only when both are full.
// Reset clears the valid bits, PI registers and version-B flag.
`default_nettype none

module rds_block_check_correct (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  rbc_blk_if.sink                          blk_i,
  rbc_res_if.source                        res_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [0:0]                  cfg_idx_i,
  input  wire logic [rbc_pkg::DataW-1:0]   cfg_wdata_i
);

  logic                        s1_valid_q, s1_valid_d;
  logic [rbc_pkg::CwW-1:0]     bits_q;
  logic [rbc_pkg::IdxW-1:0]    idx_q;
  logic                        out_valid_q, out_valid_d;
  rbc_pkg::rbc_res_t           out_q;
  logic                        ver_b_q, ver_b_d;
  logic [rbc_pkg::DataW-1:0]   pi_primary_q, pi_primary_d;
  logic [rbc_pkg::DataW-1:0]   pi_secondary_q, pi_secondary_d;

  logic                        s1_adv;
  logic                        blk_acc;
  logic [rbc_pkg::SynW-1:0]    syn;
  rbc_pkg::rbc_res_t           res;

  rbc_syndrome u_syndrome (
    .received_bits_i (bits_q),
    .block_index_i   (idx_q),
    .ver_b_i         (ver_b_q),
    .syn_o           (syn)
  );

  rbc_trap u_trap (
    .syn_i          (syn),
    .raw_data_i     (bits_q[rbc_pkg::CwW-1:rbc_pkg::SynW]),
    .block_index_i  (idx_q),
    .pi_primary_i   (pi_primary_q),
    .pi_secondary_i (pi_secondary_q),
    .res_o          (res)
  );

  assign s1_adv      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign blk_i.ready = !s1_valid_q || s1_adv;
  assign blk_acc     = blk_i.valid && blk_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (blk_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end

    ver_b_d = ver_b_q;
    if (s1_adv && idx_q == rbc_pkg::BlkB) begin
      ver_b_d = res.data_word[rbc_pkg::VerBBit];
    end

    pi_primary_d   = pi_primary_q;
    pi_secondary_d = pi_secondary_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rbc_pkg::CfgPiPrimary:   pi_primary_d   = cfg_wdata_i;
        rbc_pkg::CfgPiSecondary: pi_secondary_d = cfg_wdata_i;
        default:                 pi_primary_d   = pi_primary_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      ver_b_q        <= 1'b0;
      pi_primary_q   <= '0;
      pi_secondary_q <= '0;
    end else begin
      s1_valid_q     <= s1_valid_d;
      out_valid_q    <= out_valid_d;
      ver_b_q        <= ver_b_d;
      pi_primary_q   <= pi_primary_d;
      pi_secondary_q <= pi_secondary_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_acc) begin
      bits_q <= blk_i.received_bits;
      idx_q  <= blk_i.block_index;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.data_word    = out_q.data_word;
  assign res_o.status       = out_q.status;
  assign res_o.burst_length = out_q.burst_length;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// testbench: self-checking bench for rds_block_check_correct (syndrome, offset removal,
// burst trapping, PI check, version-B flag). Directed table first, then random phases.
// Depends on rbc_pkg, rbc_if and the RTL under src.
`timescale 1ns / 100ps

module testbench;
  import rbc_pkg::*;

  typedef enum logic {RowBlock, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [CwW-1:0]   bits;
    blk_pos_e         pos;
    cfg_reg_e         sel;
    logic [DataW-1:0] value;
    bit               pinned;
    rbc_res_t         want;
  } plan_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [0:0]           cfg_idx_i;
  logic [DataW-1:0]     cfg_wdata_i;

  rbc_blk_if blk ();
  rbc_res_if res ();

  rds_block_check_correct dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_i       (blk),
    .res_o       (res),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // mirror of the block's PI registers and version-B flag
  logic [DataW-1:0] pi_prim_m;
  logic [DataW-1:0] pi_sec_m;
  bit               ver_b_m;

  rbc_res_t  results_due[$];
  plan_row_t plan[$];
  int        errors;
  bit        tx_gaps;
  bit        rx_stalls;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("rds_block_check_correct test failed");
    $finish;
  end

  // mostly short, now and then long
  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 3);
  endfunction

  function automatic logic [SynW-1:0] block_syndrome(logic [CwW-1:0] bits);
    logic [SynW:0] s;
    s = '0;
    for (int i = CwW - 1; i >= 0; i--) begin
      s = {s[SynW-1:0], bits[i]};
      if (s[SynW]) s = s ^ GenPoly;
    end
    return s[SynW-1:0];
  endfunction

  function automatic logic [CwW-1:0] encode(logic [DataW-1:0] info, logic [SynW-1:0] offs);
    return {info, block_syndrome({info, {SynW{1'b0}}}) ^ offs};
  endfunction

  function automatic logic [BlenW-1:0] burst_span(logic [MaxBurstLen-1:0] pat);
    int lo;
    int hi;
    lo = -1;
    hi = -1;
    for (int k = 0; k < MaxBurstLen; k++) begin
      if (pat[k]) begin
        if (lo < 0) lo = k;
        hi = k;
      end
    end
    return (lo < 0) ? '0 : BlenW'(hi - lo + 1);
  endfunction

  // expected result for one block; advances the version-B flag
  function automatic rbc_res_t correct_block(logic [CwW-1:0] bits, blk_pos_e pos);
    logic [SynW:0]    syn;
    logic [SynW-1:0]  offs;
    logic [31:0]      fix;
    bit               done;
    rbc_res_t         r;
    case (pos)
      BlkA:    offs = OffsetA;
      BlkB:    offs = OffsetB;
      BlkC:    offs = ver_b_m ? OffsetCp : OffsetC;
      default: offs = OffsetD;
    endcase
    syn = {1'b0, block_syndrome(bits) ^ offs};
    r.data_word    = bits[CwW-1:SynW];
    r.status       = StUncorrectable;
    r.burst_length = '0;
    done = 1'b0;
    for (int i = 0; i < TrapSteps && !done; i++) begin
      if (syn[SynW:MaxBurstLen] == '0) begin
        done = 1'b1;
        r.burst_length = burst_span(syn[MaxBurstLen-1:0]);
        fix = (32'(syn[MaxBurstLen-1:0]) << i) >> SynW;
        r.data_word = r.data_word ^ fix[DataW-1:0];
        r.status = (r.burst_length != 0) ? StCorrected : StClean;
        if (pos == BlkA && pi_prim_m != 0 && r.burst_length != 0 &&
            r.data_word != pi_prim_m && r.data_word != pi_sec_m)
          r.status = StIdMismatch;
      end else begin
        if (syn[0]) syn = syn ^ GenPoly;
        syn = syn >> 1;
      end
    end
    if (pos == BlkB) ver_b_m = r.data_word[VerBBit];
    return r;
  endfunction

  function automatic void add_blk(logic [CwW-1:0] bits, blk_pos_e pos);
    plan_row_t row;
    row.kind   = RowBlock;
    row.bits   = bits;
    row.pos    = pos;
    row.sel    = CfgPiPrimary;
    row.value  = '0;
    row.pinned = 1'b0;
    row.want   = '0;
    plan.push_back(row);
  endfunction

  function automatic void add_pinned(logic [CwW-1:0] bits, blk_pos_e pos,
                                     logic [DataW-1:0] data, status_e st,
                                     logic [BlenW-1:0] blen);
    plan_row_t row;
    row.kind   = RowBlock;
    row.bits   = bits;
    row.pos    = pos;
    row.sel    = CfgPiPrimary;
    row.value  = '0;
    row.pinned = 1'b1;
    row.want.data_word    = data;
    row.want.status       = st;
    row.want.burst_length = blen;
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(cfg_reg_e sel, logic [DataW-1:0] v);
    plan_row_t row;
    row.kind   = RowCfg;
    row.bits   = '0;
    row.pos    = BlkA;
    row.sel    = sel;
    row.value  = v;
    row.pinned = 1'b0;
    row.want   = '0;
    plan.push_back(row);
  endfunction

  task automatic send_block(logic [CwW-1:0] bits, blk_pos_e pos, bit pinned, rbc_res_t want);
    int       gap;
    rbc_res_t got;
    gap = (tx_gaps && $urandom_range(0, 99) >= 55) ? idle_len() : 0;
    if (gap > 0) begin
      blk.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    blk.valid         <= 1'b1;
    blk.received_bits <= bits;
    blk.block_index   <= pos;
    do @(posedge clk_i); while (!blk.ready);
    got = correct_block(bits, pos);
    results_due.push_back(pinned ? want : got);
  endtask

  task automatic wait_results_done();
    blk.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_pi(cfg_reg_e sel, logic [DataW-1:0] v);
    wait_results_done();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CfgPiPrimary) pi_prim_m = v;
    else pi_sec_m = v;
  endtask

  // codewords with random data, over half carrying a burst (some longer than MaxBurstLen), a few noise
  task automatic run_random(int n, bit gaps, bit stalls);
    logic [CwW-1:0]   word;
    logic [DataW-1:0] info;
    logic [SynW-1:0]  offs;
    logic [SynW-1:0]  pat;
    blk_pos_e         pos;
    int               len;
    int               pick;
    rbc_res_t         none;
    tx_gaps   = gaps;
    rx_stalls = stalls;
    none      = '0;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) wait_results_done();
      pos  = blk_pos_e'($urandom_range(0, 3));
      pick = $urandom_range(0, 5);
      if (pos == BlkA && pick == 0) info = pi_prim_m;
      else if (pos == BlkA && pick == 1) info = pi_sec_m;
      else info = DataW'($urandom);
      case (pos)
        BlkA:    offs = OffsetA;
        BlkB:    offs = OffsetB;
        BlkC:    offs = (ver_b_m && $urandom_range(0, 7) != 0) ? OffsetCp : OffsetC;
        default: offs = OffsetD;
      endcase
      word = encode(info, offs);
      pick = $urandom_range(0, 99);
      if (pick >= 35 && pick < 90) begin
        len = (pick < 80) ? $urandom_range(1, MaxBurstLen) : $urandom_range(MaxBurstLen + 1, 10);
        pat = (SynW'($urandom) & SynW'((1 << len) - 1)) | SynW'(1) | (SynW'(1) << (len - 1));
        word = word ^ (CwW'(pat) << $urandom_range(0, CwW - len));
      end else if (pick >= 90) begin
        word = CwW'($urandom);
      end
      send_block(word, pos, 1'b0, none);
    end
  endtask

  initial begin : rx_side
    int hold;
    hold = 0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_stalls && hold == 0 && $urandom_range(0, 3) == 0) hold = idle_len();
      if (hold > 0) begin
        res.ready <= 1'b0;
        hold--;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    rbc_res_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (results_due.size() == 0) begin
        $error("result beat with nothing expected: data_word %h status %0d burst_length %0d",
               res.data_word, res.status, res.burst_length);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (res.data_word !== want.data_word) begin
          $error("data_word mismatch: expected %h, got %h", want.data_word, res.data_word);
          errors++;
        end
        if (res.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, res.status);
          errors++;
        end
        if (res.burst_length !== want.burst_length) begin
          $error("burst_length mismatch: expected %0d, got %0d",
                 want.burst_length, res.burst_length);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    errors            = 0;
    tx_gaps           = 1'b1;
    rx_stalls         = 1'b1;
    pi_prim_m         = '0;
    pi_sec_m          = '0;
    ver_b_m           = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CfgPiPrimary;
    cfg_wdata_i       = '0;
    blk.valid         = 1'b0;
    blk.received_bits = '0;
    blk.block_index   = BlkA;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity check off after reset
    add_pinned(encode(16'h0000, OffsetA), BlkA, 16'h0000, StClean, 3'd0);
    add_pinned(encode(16'hFFFF, OffsetD), BlkD, 16'hFFFF, StClean, 3'd0);
    add_blk(26'h0000000, BlkA);
    add_blk(26'h3FFFFFF, BlkC);
    add_pinned(encode(16'h0000, OffsetA) ^ 26'h1, BlkA, 16'h0000, StCorrected, 3'd1);
    add_pinned(encode(16'h0000, OffsetB) ^ 26'h1F, BlkB, 16'h0000, StCorrected, 3'd5);
    add_blk(encode(16'h1234, OffsetC) ^ (26'h1F << 21), BlkC);
    add_blk(encode(16'hABCD, OffsetD) ^ (26'h21 << 8), BlkD);
    // B word with the version bit set switches C to the C-prime offset
    add_pinned(encode(16'h0800, OffsetB), BlkB, 16'h0800, StClean, 3'd0);
    add_pinned(encode(16'h5A5A, OffsetCp), BlkC, 16'h5A5A, StClean, 3'd0);
    add_blk(encode(16'h5A5A, OffsetC), BlkC);
    add_blk(26'h2AAAAAA, BlkB);
    add_blk(encode(16'h5A5A, OffsetC), BlkC);
    add_cfg(CfgPiPrimary, 16'h1234);
    add_cfg(CfgPiSecondary, 16'h0000);
    add_pinned(encode(16'h1234, OffsetA) ^ 26'h3, BlkA, 16'h1234, StCorrected, 3'd2);
    // corrected zero passes while the secondary code is zero
    add_pinned(encode(16'h0000, OffsetA) ^ 26'h1, BlkA, 16'h0000, StCorrected, 3'd1);
    add_pinned(encode(16'h4321, OffsetA) ^ 26'h1, BlkA, 16'h4321, StIdMismatch, 3'd1);
    add_pinned(encode(16'h4321, OffsetA), BlkA, 16'h4321, StClean, 3'd0);
    add_cfg(CfgPiSecondary, 16'hFFFF);
    add_pinned(encode(16'h0000, OffsetA) ^ 26'h1, BlkA, 16'h0000, StIdMismatch, 3'd1);
    add_pinned(encode(16'hFFFF, OffsetA) ^ (26'h1 << 10), BlkA, 16'hFFFF, StCorrected, 3'd1);
    add_cfg(CfgPiPrimary, 16'hFFFF);
    add_pinned(encode(16'h8000, OffsetA) ^ 26'h3, BlkA, 16'h8000, StIdMismatch, 3'd2);
    add_cfg(CfgPiPrimary, 16'h0000);
    add_pinned(encode(16'h8000, OffsetA) ^ 26'h3, BlkA, 16'h8000, StCorrected, 3'd2);
    add_blk(26'h3FFFFFF, BlkB);
    add_blk(26'h1555555, BlkD);

    foreach (plan[i]) begin
      if (plan[i].kind == RowCfg) write_pi(plan[i].sel, plan[i].value);
      else send_block(plan[i].bits, plan[i].pos, plan[i].pinned, plan[i].want);
    end

    write_pi(CfgPiPrimary, DataW'($urandom_range(1, 65535)));
    write_pi(CfgPiSecondary, DataW'($urandom));
    run_random(120, 1'b1, 1'b1);
    write_pi(CfgPiPrimary, 16'hFFFF);
    write_pi(CfgPiSecondary, 16'h0000);
    run_random(100, 1'b0, 1'b0);
    write_pi(CfgPiPrimary, 16'h0001);
    write_pi(CfgPiSecondary, 16'hFFFF);
    run_random(100, 1'b1, 1'b0);
    write_pi(CfgPiPrimary, 16'h0000);
    write_pi(CfgPiSecondary, DataW'($urandom));
    run_random(80, 1'b0, 1'b1);
    write_pi(CfgPiPrimary, DataW'($urandom_range(1, 65535)));
    write_pi(CfgPiSecondary, DataW'($urandom));
    run_random(100, 1'b1, 1'b1);

    wait_results_done();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("rds_block_check_correct test passed");
    end else begin
      $display("rds_block_check_correct test failed");
    end
    $finish;
  end

endmodule
